// ----- rtl/core/stb_pkg.sv -----
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants of the source byte tokenizer: token codes,
// keyword byte table and the command/status bundles between its modules.
// ----------------------------------------------------------------------------
package stb_pkg;

  // Token type codes
  localparam logic [4:0] TT_IDENT   = 5'd5;
  localparam logic [4:0] TT_INT     = 5'd6;
  localparam logic [4:0] TT_DEC     = 5'd7;
  localparam logic [4:0] TT_PLUS    = 5'd8;
  localparam logic [4:0] TT_MINUS   = 5'd9;
  localparam logic [4:0] TT_STAR    = 5'd10;
  localparam logic [4:0] TT_SLASH   = 5'd11;
  localparam logic [4:0] TT_ASSIGN  = 5'd12;
  localparam logic [4:0] TT_EQEQ    = 5'd13;
  localparam logic [4:0] TT_NEQ     = 5'd14;
  localparam logic [4:0] TT_LT      = 5'd15;
  localparam logic [4:0] TT_LE      = 5'd16;
  localparam logic [4:0] TT_GT      = 5'd17;
  localparam logic [4:0] TT_GE      = 5'd18;
  localparam logic [4:0] TT_LPAREN  = 5'd19;
  localparam logic [4:0] TT_RPAREN  = 5'd20;
  localparam logic [4:0] TT_LBRACE  = 5'd21;
  localparam logic [4:0] TT_RBRACE  = 5'd22;
  localparam logic [4:0] TT_SEMI    = 5'd23;
  localparam logic [4:0] TT_EOF     = 5'd24;
  localparam logic [4:0] TT_BADBANG = 5'd25;
  localparam logic [4:0] TT_UNKNOWN = 5'd26;

  // Pending token kinds
  localparam logic [3:0] K_IDLE  = 4'd0;
  localparam logic [3:0] K_IDENT = 4'd1;
  localparam logic [3:0] K_INT   = 4'd2;
  localparam logic [3:0] K_DEC   = 4'd3;
  localparam logic [3:0] K_CAND  = 4'd4;
  localparam logic [3:0] K_EQ    = 4'd5;
  localparam logic [3:0] K_BANG  = 4'd6;
  localparam logic [3:0] K_LT    = 4'd7;
  localparam logic [3:0] K_GT    = 4'd8;

  localparam int KW_COUNT   = 5;
  localparam int KW_LONGEST = 18;

  localparam logic [7:0] KW_BYTES [KW_COUNT][KW_LONGEST] = '{
    '{8'hE0,8'hA6,8'hB8,8'hE0,8'hA6,8'h82,8'hE0,8'hA6,8'h96,
      8'hE0,8'hA7,8'h8D,8'hE0,8'hA6,8'hAF,8'hE0,8'hA6,8'hBE},
    '{8'hE0,8'hA6,8'hA6,8'hE0,8'hA6,8'hB6,8'hE0,8'hA6,8'hAE,
      8'hE0,8'hA6,8'hBF,8'hE0,8'hA6,8'h95,8'h00,8'h00,8'h00},
    '{8'hE0,8'hA6,8'hAF,8'hE0,8'hA6,8'hA6,8'hE0,8'hA6,8'hBF,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hE0,8'hA6,8'hA8,8'hE0,8'hA6,8'hBE,8'hE0,8'hA6,8'hB9,
      8'hE0,8'hA6,8'hB2,8'hE0,8'hA7,8'h87,8'h00,8'h00,8'h00},
    '{8'hE0,8'hA6,8'hAF,8'hE0,8'hA6,8'hA4,8'hE0,8'hA6,8'h95,
      8'hE0,8'hA7,8'h8D,8'hE0,8'hA6,8'hB7,8'hE0,8'hA6,8'hA3}
  };

  localparam logic [5:0] KW_LEN [KW_COUNT] = '{6'd18, 6'd15, 6'd9, 6'd15, 6'd18};

  // Keyword byte at a position; zero past the table
  function automatic logic [7:0] kw_byte(input logic [2:0] k, input logic [4:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (32'(idx) < KW_LONGEST && 32'(k) < KW_COUNT) begin
      b = KW_BYTES[k][idx];
    end
    return b;
  endfunction

  typedef struct packed {
    logic accept;
    logic run;
    logic eof;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic sym_done;
    logic is_eof;
    logic eof_done;
    logic flush_done;
  } sts_t;

endpackage

// ----- rtl/core/stb_ctrl.sv -----
// ----------------------------------------------------------------------------
// stb_ctrl
// Sequencer of the tokenizer: accept an item, run scan steps until the item
// is consumed, add the end token when asked, then release the last token.
// ----------------------------------------------------------------------------
module stb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output stb_pkg::cmd_t cmd_o,
  input  stb_pkg::sts_t sts_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_EOF   = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_RUN;
      end
      S_RUN: begin
        if (sts_i.sym_done) state_d = sts_i.is_eof ? S_EOF : S_FLUSH;
      end
      S_EOF: begin
        if (sts_i.eof_done) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (sts_i.flush_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign cmd_o.accept = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.run    = (state_q == S_RUN);
  assign cmd_o.eof    = (state_q == S_EOF);
  assign cmd_o.flush  = (state_q == S_FLUSH);

endmodule

// ----- rtl/core/stb_datapath.sv -----
// ----------------------------------------------------------------------------
// stb_datapath
// Scan state, keyword byte buffer with rescan pointer, one token staging
// register and the output register.
// ----------------------------------------------------------------------------
module stb_datapath #(
  parameter int MAX_KEYWORD_BYTES = 18,
  parameter int OFFSET_BITS       = 24,
  parameter int LINE_BITS         = 16,
  parameter int LENGTH_BITS       = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stb_pkg::cmd_t          cmd_i,
  output stb_pkg::sts_t          sts_o,
  input  logic                   op_i,
  input  logic [7:0]             source_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [4:0]             token_type_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [LENGTH_BITS-1:0] token_length_o,
  output logic [LINE_BITS-1:0]   line_number_o,
  output logic                   last_o
);

  localparam int PTR_W = $clog2(MAX_KEYWORD_BYTES);
  localparam int DEPTH = 1 << PTR_W;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A)) || (b == 8'h5F);
  endfunction

  // Held item
  logic                   op_q;
  logic [7:0]             byte_q;
  logic [OFFSET_BITS-1:0] off_q;

  // Scan state
  logic [OFFSET_BITS-1:0] boff_q;
  logic [LINE_BITS-1:0]   line_q, line_n;
  logic [3:0]             kind_q, kind_n;
  logic [OFFSET_BITS-1:0] start_q, start_n;
  logic [LENGTH_BITS-1:0] plen_q, plen_n;
  logic [4:0]             cand_q, cand_n;

  // Keyword buffer: base..rd-1 is the live window, rd..wr-1 awaits rescan
  logic [7:0]             buf_q [DEPTH];
  logic [PTR_W-1:0]       base_q, rd_q, wr_q, base_n;
  logic [OFFSET_BITS-1:0] rd_off_q;

  // Staging and output registers
  logic                   r_valid_q;
  logic [4:0]             r_type_q;
  logic [OFFSET_BITS-1:0] r_start_q;
  logic [LENGTH_BITS-1:0] r_len_q;
  logic [LINE_BITS-1:0]   r_line_q;
  logic                   out_valid_q;
  logic [4:0]             out_type_q;
  logic [OFFSET_BITS-1:0] out_start_q;
  logic [LENGTH_BITS-1:0] out_len_q;
  logic [LINE_BITS-1:0]   out_line_q;
  logic                   out_last_q;

  // Current symbol
  logic                   sym_rep, sym_eof;
  logic [7:0]             sym_byte;
  logic [OFFSET_BITS-1:0] sym_off;
  logic [PTR_W-1:0]       fill;
  logic [5:0]             fill_x, fill_nx;
  logic [4:0]             cont_mask, start_mask;

  // Step result
  logic                   st_emit, consume, keep, rewind;
  logic [4:0]             e_type;
  logic [OFFSET_BITS-1:0] e_start;
  logic [LENGTH_BITS-1:0] e_len;

  logic out_free, hold, fire, eof_ok, flush_ok, push, push_last;

  assign sym_rep  = (rd_q != wr_q);
  assign sym_eof  = !sym_rep && op_q;
  assign sym_byte = sym_rep ? buf_q[rd_q] : byte_q;
  assign sym_off  = sym_rep ? rd_off_q : off_q;
  assign fill     = rd_q - base_q;
  assign fill_x   = 6'(fill);
  assign fill_nx  = fill_x + 6'd1;

  always_comb begin
    for (int k = 0; k < stb_pkg::KW_COUNT; k++) begin
      cont_mask[k]  = cand_q[k] && (fill_x < stb_pkg::KW_LEN[k]) &&
                      (stb_pkg::kw_byte(3'(k), fill_x[4:0]) == sym_byte);
      start_mask[k] = (stb_pkg::KW_BYTES[k][0] == sym_byte) &&
                      (32'(stb_pkg::KW_LEN[k]) <= MAX_KEYWORD_BYTES);
    end
  end

  // One scan step: at most one token, the symbol is consumed or kept
  always_comb begin
    st_emit = 1'b0;
    consume = 1'b0;
    keep    = 1'b0;
    rewind  = 1'b0;
    e_type  = stb_pkg::TT_UNKNOWN;
    e_start = start_q;
    e_len   = LENGTH_BITS'(1);
    kind_n  = kind_q;
    start_n = start_q;
    plen_n  = plen_q;
    cand_n  = cand_q;
    base_n  = base_q;
    line_n  = line_q;
    unique case (kind_q)
      stb_pkg::K_CAND: begin
        if (!sym_eof && cont_mask != 5'd0 && 32'(fill_x) < MAX_KEYWORD_BYTES) begin
          consume = 1'b1;
          keep    = 1'b1;
          cand_n  = cont_mask;
          for (int k = stb_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (cont_mask[k] && stb_pkg::KW_LEN[k] == fill_nx) begin
              st_emit = 1'b1;
              e_type  = 5'(k);
              e_len   = (32'(fill_nx) > 32'(LEN_MAX)) ? LEN_MAX : LENGTH_BITS'(fill_nx);
            end
          end
          if (st_emit) begin
            kind_n = stb_pkg::K_IDLE;
            cand_n = 5'h1F;
          end
        end else begin
          // drop the first window byte as unknown, rescan the rest
          st_emit = 1'b1;
          rewind  = 1'b1;
          kind_n  = stb_pkg::K_IDLE;
          cand_n  = 5'h1F;
          base_n  = base_q + PTR_W'(1);
        end
      end
      stb_pkg::K_IDENT, stb_pkg::K_INT, stb_pkg::K_DEC: begin
        if (!sym_eof && (is_digit(sym_byte) ||
            (kind_q == stb_pkg::K_IDENT && is_alpha(sym_byte)) ||
            (kind_q == stb_pkg::K_INT && sym_byte == 8'h2E))) begin
          consume = 1'b1;
          if (plen_q < LEN_MAX) plen_n = plen_q + LENGTH_BITS'(1);
          if (kind_q == stb_pkg::K_INT && sym_byte == 8'h2E) kind_n = stb_pkg::K_DEC;
        end else begin
          st_emit = 1'b1;
          e_len   = plen_q;
          e_type  = (kind_q == stb_pkg::K_IDENT) ? stb_pkg::TT_IDENT :
                    (kind_q == stb_pkg::K_INT)   ? stb_pkg::TT_INT : stb_pkg::TT_DEC;
          kind_n  = stb_pkg::K_IDLE;
        end
      end
      stb_pkg::K_EQ, stb_pkg::K_BANG, stb_pkg::K_LT, stb_pkg::K_GT: begin
        st_emit = 1'b1;
        kind_n  = stb_pkg::K_IDLE;
        if (!sym_eof && sym_byte == 8'h3D) begin
          consume = 1'b1;
          e_len   = LENGTH_BITS'(2);
          e_type  = (kind_q == stb_pkg::K_EQ)   ? stb_pkg::TT_EQEQ :
                    (kind_q == stb_pkg::K_BANG) ? stb_pkg::TT_NEQ :
                    (kind_q == stb_pkg::K_LT)   ? stb_pkg::TT_LE : stb_pkg::TT_GE;
        end else begin
          e_type  = (kind_q == stb_pkg::K_EQ)   ? stb_pkg::TT_ASSIGN :
                    (kind_q == stb_pkg::K_BANG) ? stb_pkg::TT_BADBANG :
                    (kind_q == stb_pkg::K_LT)   ? stb_pkg::TT_LT : stb_pkg::TT_GT;
        end
      end
      default: begin
        consume = 1'b1;
        e_start = sym_off;
        if (sym_eof || sym_byte == 8'h20 || sym_byte == 8'h09 || sym_byte == 8'h0D) begin
          kind_n = stb_pkg::K_IDLE;
        end else if (sym_byte == 8'h0A) begin
          if (line_q < LINE_MAX) line_n = line_q + LINE_BITS'(1);
        end else if (start_mask != 5'd0) begin
          keep    = 1'b1;
          kind_n  = stb_pkg::K_CAND;
          start_n = sym_off;
          cand_n  = start_mask;
          base_n  = rd_q;
        end else begin
          start_n = sym_off;
          plen_n  = LENGTH_BITS'(1);
          if (is_alpha(sym_byte)) begin
            kind_n = stb_pkg::K_IDENT;
          end else if (is_digit(sym_byte)) begin
            kind_n = stb_pkg::K_INT;
          end else begin
            unique case (sym_byte)
              8'h3D:   kind_n = stb_pkg::K_EQ;
              8'h21:   kind_n = stb_pkg::K_BANG;
              8'h3C:   kind_n = stb_pkg::K_LT;
              8'h3E:   kind_n = stb_pkg::K_GT;
              default: st_emit = 1'b1;
            endcase
            unique case (sym_byte)
              8'h2B:   e_type = stb_pkg::TT_PLUS;
              8'h2D:   e_type = stb_pkg::TT_MINUS;
              8'h2A:   e_type = stb_pkg::TT_STAR;
              8'h2F:   e_type = stb_pkg::TT_SLASH;
              8'h28:   e_type = stb_pkg::TT_LPAREN;
              8'h29:   e_type = stb_pkg::TT_RPAREN;
              8'h7B:   e_type = stb_pkg::TT_LBRACE;
              8'h7D:   e_type = stb_pkg::TT_RBRACE;
              8'h3B:   e_type = stb_pkg::TT_SEMI;
              default: e_type = stb_pkg::TT_UNKNOWN;
            endcase
          end
        end
      end
    endcase
  end

  assign out_free  = !out_valid_q || !out_stall_i;
  assign hold      = st_emit && r_valid_q && !out_free;
  assign fire      = cmd_i.run && !hold;
  assign eof_ok    = cmd_i.eof && !(r_valid_q && !out_free);
  assign flush_ok  = cmd_i.flush && r_valid_q && out_free;
  assign push      = r_valid_q && ((fire && st_emit) || eof_ok || flush_ok);
  assign push_last = cmd_i.flush;

  assign sts_o.sym_done   = fire && consume && !sym_rep;
  assign sts_o.is_eof     = op_q;
  assign sts_o.eof_done   = eof_ok;
  assign sts_o.flush_done = !r_valid_q || out_free;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boff_q      <= '0;
      line_q      <= LINE_BITS'(1);
      kind_q      <= stb_pkg::K_IDLE;
      cand_q      <= 5'h1F;
      base_q      <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      r_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && !op_i) boff_q <= boff_q + OFFSET_BITS'(1);
      if (fire) begin
        line_q <= line_n;
        kind_q <= kind_n;
        cand_q <= cand_n;
        base_q <= base_n;
        if (rewind) begin
          rd_q <= base_q + PTR_W'(1);
        end else if (consume && sym_rep) begin
          rd_q <= rd_q + PTR_W'(1);
        end else if (consume && keep) begin
          rd_q <= rd_q + PTR_W'(1);
          wr_q <= wr_q + PTR_W'(1);
        end
      end
      if (eof_ok) begin
        boff_q <= '0;
        line_q <= LINE_BITS'(1);
        kind_q <= stb_pkg::K_IDLE;
        cand_q <= 5'h1F;
      end
      if ((fire && st_emit) || eof_ok) begin
        r_valid_q <= 1'b1;
      end else if (flush_ok) begin
        r_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_i;
      byte_q <= source_byte_i;
      off_q  <= boff_q;
    end
    if (fire) begin
      start_q <= start_n;
      plen_q  <= plen_n;
      if (rewind) begin
        rd_off_q <= start_q + OFFSET_BITS'(1);
      end else if (consume && sym_rep) begin
        rd_off_q <= rd_off_q + OFFSET_BITS'(1);
      end
      if (consume && keep && !sym_rep) buf_q[wr_q] <= sym_byte;
      if (st_emit) begin
        r_type_q  <= e_type;
        r_start_q <= e_start;
        r_len_q   <= e_len;
        r_line_q  <= line_q;
      end
    end
    if (eof_ok) begin
      r_type_q  <= stb_pkg::TT_EOF;
      r_start_q <= boff_q;
      r_len_q   <= '0;
      r_line_q  <= line_q;
    end
    if (push) begin
      out_type_q  <= r_type_q;
      out_start_q <= r_start_q;
      out_len_q   <= r_len_q;
      out_line_q  <= r_line_q;
      out_last_q  <= push_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign token_type_o   = out_type_q;
  assign start_offset_o = out_start_q;
  assign token_length_o = out_len_q;
  assign line_number_o  = out_line_q;
  assign last_o         = out_last_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kind_q == stb_pkg::K_CAND |-> 32'(fill_x) < MAX_KEYWORD_BYTES)
    else $error("keyword window overran its bound");
  a_no_token_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && st_emit && r_valid_q |-> out_free)
    else $error("staged token overwritten");
  a_clean_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> !r_valid_q && rd_q == wr_q)
    else $error("item accepted with leftover work");
`endif

endmodule

// ----- rtl/core/source_byte_tokenizer.sv -----
// ----------------------------------------------------------------------------
// source_byte_tokenizer
// Streaming lexical tokenizer with keyword match over source bytes.
// ----------------------------------------------------------------------------
// Feed one source byte per item (op_i = 0) or an end-of-source item (op_i = 1)
// and take tokens as type, start offset, length and line, with last_o on the
// final token of each item. Each item passes through accept, one scan step and
// release of the staged token. Add one scan step for every pending token that
// a byte closes without being consumed (the byte is then scanned again), and
// one for a failed partial keyword match plus one for each byte replayed after
// it; an end-of-source item also stages its end token before the release. A
// stalled output holds the scan whenever a second token is due, and holds the
// release. The scan step visits one symbol a cycle while the output does not
// hold it, with at most one token per visit, and a staging register holds each
// token until the next shows whether it is the last of its item. Failed
// keyword prefixes are kept in a small byte buffer and rescanned from it.
module source_byte_tokenizer #(
  parameter int MAX_KEYWORD_BYTES = 18,
  parameter int OFFSET_BITS       = 24,
  parameter int LINE_BITS         = 16,
  parameter int LENGTH_BITS       = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // item input
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   op_i,
  input  logic [7:0]             source_byte_i,
  // token output
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [4:0]             token_type_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [LENGTH_BITS-1:0] token_length_o,
  output logic [LINE_BITS-1:0]   line_number_o,
  output logic                   last_o
);

  stb_pkg::cmd_t cmd;
  stb_pkg::sts_t sts;

  // Sequencer: accept, scan, end token, release
  stb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Scan state, keyword buffer, staging and output registers
  stb_datapath #(
    .MAX_KEYWORD_BYTES (MAX_KEYWORD_BYTES),
    .OFFSET_BITS       (OFFSET_BITS),
    .LINE_BITS         (LINE_BITS),
    .LENGTH_BITS       (LENGTH_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .source_byte_i  (source_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_type_o   (token_type_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .line_number_o  (line_number_o),
    .last_o         (last_o)
  );

endmodule
